// File: rtl/box_center_ray_gap_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the box_center_ray_gap RTL
// Each macro expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef BOX_CENTER_RAY_GAP_MACROS_SVH
`define BOX_CENTER_RAY_GAP_MACROS_SVH

// same-cycle implication
`define BCRG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCRG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bcrg_pkg.sv
// ----------------------------------------------------------------------------
// bcrg_pkg
// Types, widths and constants of the box centre-line gap block.
// ----------------------------------------------------------------------------
package bcrg_pkg;

  // field and datapath widths
  localparam int CoordW   = 32;
  localparam int HalfW    = 31;
  localparam int DiffW    = CoordW + 1;          // centre difference magnitude
  localparam int ProdW    = DiffW + HalfW;       // |d|*half extent
  localparam int SumW     = 2 * DiffW;           // dx^2 + dy^2
  localparam int RootBits = 35;                  // root bits resolved
  localparam int TrialW   = 2 * RootBits + 1;    // root trial term
  localparam int NumPW    = HalfW + RootBits;    // half extent * distance
  localparam int QuoBits  = 41;                  // quotient bits resolved
  localparam int LenW     = QuoBits;
  localparam int GapFullW = LenW + 2;
  localparam int StatW    = 2;

  // exit length cap, 2^40
  localparam logic [LenW-1:0] LenCap = LenW'(64'h100_0000_0000);

  // default queue depths (powers of two)
  localparam int MidDepth = 4;
  localparam int OutDepth = 2;

  typedef enum logic [StatW-1:0] {
    STAT_OK         = 2'd0,
    STAT_COINCIDENT = 2'd1,
    STAT_FLAT_VERT  = 2'd2
  } bcrg_status_e;

  typedef struct packed {
    logic signed [CoordW-1:0] first_center_x;
    logic signed [CoordW-1:0] first_center_y;
    logic [HalfW-1:0]         first_half_width;
    logic [HalfW-1:0]         first_half_height;
    logic signed [CoordW-1:0] second_center_x;
    logic signed [CoordW-1:0] second_center_y;
    logic [HalfW-1:0]         second_half_width;
    logic [HalfW-1:0]         second_half_height;
  } bcrg_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] gap;
    logic [StatW-1:0]         status;
  } bcrg_out_t;

  // classified pair handed from front to back
  typedef struct packed {
    logic [DiffW-1:0]            adx;
    logic [DiffW-1:0]            ady;
    logic [1:0][HalfW-1:0]       num;
    logic [1:0][DiffW-1:0]       den;
    bcrg_status_e                status;
    logic [RootBits-1:0]         span;
    logic [1:0]                  ovf;
  } bcrg_work_t;

endpackage

// File: rtl/box_center_ray_gap.sv
// ----------------------------------------------------------------------------
// box_center_ray_gap
// Gap between two axis-aligned boxes along the line joining their centres.
// ----------------------------------------------------------------------------
// Takes one box pair per clock while full_o is low and returns one word per
// pair, in order. A pair passes front registers A and B (differences, then
// exit-side test), waits in a MidDepth queue, then runs 80 back stages:
// squares, sum, a 35-stage root, the scaling multiply, divide set-up and a
// 41-stage divide. The back pipeline stalls as one only while the OutDepth
// result queue is full.
module box_center_ray_gap #(
  parameter int MidDepth = bcrg_pkg::MidDepth,
  parameter int OutDepth = bcrg_pkg::OutDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  bcrg_pkg::bcrg_in_t  in_i,
  output logic                empty_o,
  input  logic                pop_i,
  output bcrg_pkg::bcrg_out_t out_o
);

  localparam int WorkW = $bits(bcrg_pkg::bcrg_work_t);
  localparam int OutW  = $bits(bcrg_pkg::bcrg_out_t);

  logic                 mid_push, mid_full, mid_pop, mid_empty;
  bcrg_pkg::bcrg_work_t mid_wdata, mid_rdata;
  logic                 out_push, out_full;
  bcrg_pkg::bcrg_out_t  out_wdata;

  // front: differences and classification
  bcrg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_i       (in_i),
    .mid_push_o (mid_push),
    .mid_full_i (mid_full),
    .mid_data_o (mid_wdata)
  );

  // queue between front and back
  bcrg_fifo #(
    .Width (WorkW),
    .Depth (MidDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .empty_o (mid_empty)
  );

  // back: root, scale, divide, gap
  bcrg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .mid_data_i  (mid_rdata),
    .out_push_o  (out_push),
    .out_data_o  (out_wdata),
    .out_full_i  (out_full)
  );

  // result queue
  bcrg_fifo #(
    .Width (OutW),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (out_o),
    .empty_o (empty_o)
  );

endmodule

// File: rtl/bcrg_fifo.sv
// ----------------------------------------------------------------------------
// bcrg_fifo
// Small first-word-fall-through queue in registers; Depth a power of two.
// ----------------------------------------------------------------------------
`include "box_center_ray_gap_macros.svh"

module bcrg_fifo #(
  parameter int Width = 8,
  parameter int Depth = bcrg_pkg::MidDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `BCRG_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CntW'(Depth), "fifo count overrun")
  `BCRG_ASSERT_NXT(a_full_holds, full_o && !do_pop, full_o, "full fifo drained without pop")
  `BCRG_ASSERT_NXT(a_push_fills, do_push && !do_pop, !empty_o, "pushed word lost")

endmodule

// File: rtl/bcrg_front.sv
// ----------------------------------------------------------------------------
// bcrg_front
// Takes box pairs, forms centre differences and classifies each box exit
// as side or top/bottom; pushes the classified word into the mid queue.
// ----------------------------------------------------------------------------
module bcrg_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  bcrg_pkg::bcrg_in_t   in_i,
  output logic                 mid_push_o,
  input  logic                 mid_full_i,
  output bcrg_pkg::bcrg_work_t mid_data_o
);

  localparam int DiffW = bcrg_pkg::DiffW;
  localparam int HalfW = bcrg_pkg::HalfW;
  localparam int ProdW = bcrg_pkg::ProdW;

  logic                  a_vld_q, b_vld_q, a_adv, b_adv;
  logic [DiffW-1:0]      dx_d, dy_d, adx_d, ady_d;
  logic [DiffW-1:0]      adx_a_q, ady_a_q, adx_b_q, ady_b_q;
  logic [1:0][HalfW-1:0] w_a_q, h_a_q, w_b_q, h_b_q;
  logic [1:0][ProdW-1:0] xh_q, wy_q;
  logic [1:0]            side, undef;

  assign b_adv      = !b_vld_q || !mid_full_i;
  assign a_adv      = !a_vld_q || b_adv;
  assign full_o     = !a_adv;
  assign mid_push_o = b_vld_q;

  // centre differences and magnitudes
  assign dx_d  = DiffW'(in_i.second_center_x) - DiffW'(in_i.first_center_x);
  assign dy_d  = DiffW'(in_i.second_center_y) - DiffW'(in_i.first_center_y);
  assign adx_d = dx_d[DiffW-1] ? (~dx_d + 1'b1) : dx_d;
  assign ady_d = dy_d[DiffW-1] ? (~dy_d + 1'b1) : dy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (a_adv) a_vld_q <= push_i;
      if (b_adv) b_vld_q <= a_vld_q;
    end
  end

  // stage A: magnitudes
  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      adx_a_q  <= adx_d;
      ady_a_q  <= ady_d;
      w_a_q[0] <= in_i.first_half_width;
      h_a_q[0] <= in_i.first_half_height;
      w_a_q[1] <= in_i.second_half_width;
      h_a_q[1] <= in_i.second_half_height;
    end
  end

  // stage B: cross products for the exit test
  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      adx_b_q <= adx_a_q;
      ady_b_q <= ady_a_q;
      w_b_q   <= w_a_q;
      h_b_q   <= h_a_q;
      for (int k = 0; k < 2; k++) begin
        xh_q[k] <= ProdW'(adx_a_q) * ProdW'(h_a_q[k]);
        wy_q[k] <= ProdW'(w_a_q[k]) * ProdW'(ady_a_q);
      end
    end
  end

  // classification
  always_comb begin
    mid_data_o     = '0;
    mid_data_o.adx = adx_b_q;
    mid_data_o.ady = ady_b_q;
    for (int k = 0; k < 2; k++) begin
      side[k]  = (ady_b_q == '0) || (h_b_q[k] == '0) || (xh_q[k] > wy_q[k]);
      undef[k] = side[k] && (adx_b_q == '0);
      mid_data_o.num[k] = side[k] ? w_b_q[k] : h_b_q[k];
      mid_data_o.den[k] = side[k] ? adx_b_q : ady_b_q;
    end
    priority if ((adx_b_q == '0) && (ady_b_q == '0)) begin
      mid_data_o.status = bcrg_pkg::STAT_COINCIDENT;
    end else if (|undef) begin
      mid_data_o.status = bcrg_pkg::STAT_FLAT_VERT;
    end else begin
      mid_data_o.status = bcrg_pkg::STAT_OK;
    end
  end

endmodule

// File: rtl/bcrg_back.sv
// ----------------------------------------------------------------------------
// bcrg_back
// Stallable pipeline: squares, bit-per-stage square root, scaling
// multiply, bit-per-stage divide in two lanes, then gap and saturation.
// ----------------------------------------------------------------------------
`include "box_center_ray_gap_macros.svh"

module bcrg_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 mid_empty_i,
  output logic                 mid_pop_o,
  input  bcrg_pkg::bcrg_work_t mid_data_i,
  output logic                 out_push_o,
  output bcrg_pkg::bcrg_out_t  out_data_o,
  input  logic                 out_full_i
);

  localparam int DiffW    = bcrg_pkg::DiffW;
  localparam int SumW     = bcrg_pkg::SumW;
  localparam int RootBits = bcrg_pkg::RootBits;
  localparam int TrialW   = bcrg_pkg::TrialW;
  localparam int NumPW    = bcrg_pkg::NumPW;
  localparam int QuoBits  = bcrg_pkg::QuoBits;
  localparam int LenW     = bcrg_pkg::LenW;
  localparam int GapFullW = bcrg_pkg::GapFullW;
  localparam int CoordW   = bcrg_pkg::CoordW;

  localparam int StgSum   = 1;
  localparam int StgRoot0 = StgSum + 1;
  localparam int StgMul   = StgRoot0 + RootBits;
  localparam int StgPre   = StgMul + 1;
  localparam int StgDiv0  = StgPre + 1;
  localparam int NStg     = StgDiv0 + QuoBits;

  logic                 en;
  logic [NStg-1:0]      vld_q;
  bcrg_pkg::bcrg_work_t wk_q [NStg];
  bcrg_pkg::bcrg_work_t wk_mul_d, wk_pre_d;

  logic [SumW-1:0]      sx_q, sy_q;
  logic [SumW-1:0]      rt_e_q [RootBits+1];
  logic [RootBits-1:0]  rt_r_q [RootBits+1];
  logic [NumPW-1:0]     p_q    [2];
  logic [DiffW-1:0]     dv_rem_q [2][QuoBits+1];
  logic [QuoBits-1:0]   dv_low_q [2][QuoBits+1];
  logic [QuoBits-1:0]   dv_quo_q [2][QuoBits+1];

  // whole pipeline advances while the result queue has room
  assign en         = !out_full_i;
  assign mid_pop_o  = en && !mid_empty_i;
  assign out_push_o = en && vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], !mid_empty_i};
    end
  end

  // squares
  always_ff @(posedge clk_i) begin
    if (en) begin
      wk_q[0] <= mid_data_i;
      sx_q    <= SumW'(mid_data_i.adx) * SumW'(mid_data_i.adx);
      sy_q    <= SumW'(mid_data_i.ady) * SumW'(mid_data_i.ady);
    end
  end

  // sum of squares
  always_ff @(posedge clk_i) begin
    if (en) begin
      wk_q[StgSum] <= wk_q[0];
      rt_e_q[0]    <= sx_q + sy_q;
      rt_r_q[0]    <= '0;
    end
  end

  // square root, one result bit per stage, most significant first
  for (genvar i = 0; i < RootBits; i++) begin : g_root
    localparam int B = RootBits - 1 - i;
    logic [TrialW-1:0] trial;
    logic              take;
    assign trial = (TrialW'(rt_r_q[i]) << (B + 1)) + (TrialW'(1) << (2 * B));
    assign take  = trial <= TrialW'(rt_e_q[i]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        wk_q[StgRoot0+i] <= wk_q[StgRoot0+i-1];
        rt_e_q[i+1]      <= take ? (rt_e_q[i] - trial[SumW-1:0]) : rt_e_q[i];
        rt_r_q[i+1]      <= take ? (rt_r_q[i] | (RootBits'(1) << B)) : rt_r_q[i];
      end
    end
  end

  // word leaving the root, with the distance filled in
  always_comb begin
    wk_mul_d      = wk_q[StgMul-1];
    wk_mul_d.span = rt_r_q[RootBits];
  end

  // scale distance by the chosen half extent
  always_ff @(posedge clk_i) begin
    if (en) begin
      wk_q[StgMul] <= wk_mul_d;
      for (int k = 0; k < 2; k++) begin
        p_q[k] <= NumPW'(wk_q[StgMul-1].num[k]) * NumPW'(rt_r_q[RootBits]);
      end
    end
  end

  // early overflow when the quotient needs more bits
  always_comb begin
    wk_pre_d = wk_q[StgMul];
    for (int k = 0; k < 2; k++) begin
      wk_pre_d.ovf[k] = DiffW'(p_q[k][NumPW-1:QuoBits]) >= wk_q[StgMul].den[k];
    end
  end

  // divide set-up
  always_ff @(posedge clk_i) begin
    if (en) begin
      wk_q[StgPre] <= wk_pre_d;
      for (int k = 0; k < 2; k++) begin
        dv_rem_q[k][0] <= DiffW'(p_q[k][NumPW-1:QuoBits]);
        dv_low_q[k][0] <= p_q[k][QuoBits-1:0];
        dv_quo_q[k][0] <= '0;
      end
    end
  end

  // restoring divide, one quotient bit per stage in each lane
  for (genvar j = 0; j < QuoBits; j++) begin : g_div
    localparam int B = QuoBits - 1 - j;
    always_ff @(posedge clk_i) begin
      if (en) begin
        wk_q[StgDiv0+j] <= wk_q[StgDiv0+j-1];
      end
    end
    for (genvar k = 0; k < 2; k++) begin : g_lane
      logic [DiffW:0] cand, dsub;
      logic           ge;
      assign cand = {dv_rem_q[k][j], dv_low_q[k][j][B]};
      assign ge   = cand >= {1'b0, wk_q[StgDiv0+j-1].den[k]};
      assign dsub = cand - {1'b0, wk_q[StgDiv0+j-1].den[k]};
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_rem_q[k][j+1] <= ge ? dsub[DiffW-1:0] : cand[DiffW-1:0];
          dv_low_q[k][j+1] <= dv_low_q[k][j];
          dv_quo_q[k][j+1] <= {dv_quo_q[k][j][QuoBits-2:0], ge};
        end
      end
    end
  end

  // exit lengths, gap and saturation
  logic [1:0][LenW-1:0]  len;
  logic [GapFullW-1:0]   gfull;
  logic                  sat_hi, sat_lo;
  logic                  spec_out;
  bcrg_pkg::bcrg_work_t  wk_last;

  assign wk_last  = wk_q[NStg-1];
  assign spec_out = out_push_o && (wk_last.status != bcrg_pkg::STAT_OK);

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      len[k] = (wk_last.ovf[k] || (dv_quo_q[k][QuoBits] > bcrg_pkg::LenCap))
             ? bcrg_pkg::LenCap : dv_quo_q[k][QuoBits];
    end
    gfull  = GapFullW'(wk_last.span) - GapFullW'(len[0]) - GapFullW'(len[1]);
    sat_hi = !gfull[GapFullW-1] && (|gfull[GapFullW-2:CoordW-1]);
    sat_lo = gfull[GapFullW-1] && !(&gfull[GapFullW-2:CoordW-1]);
    out_data_o.status = wk_last.status;
    priority if (wk_last.status != bcrg_pkg::STAT_OK) begin
      out_data_o.gap = '0;
    end else if (sat_hi) begin
      out_data_o.gap = {1'b0, {(CoordW-1){1'b1}}};
    end else if (sat_lo) begin
      out_data_o.gap = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      out_data_o.gap = gfull[CoordW-1:0];
    end
  end

  `BCRG_ASSERT_IMP(a_special_zero, spec_out, out_data_o.gap == '0, "special case gap not zero")
  `BCRG_ASSERT_IMP(a_stall_hold, !en, !mid_pop_o && !out_push_o, "pipeline moved while stalled")
  `BCRG_ASSERT_IMP(a_status_legal, out_push_o, out_data_o.status <= bcrg_pkg::STAT_FLAT_VERT, "bad status")

endmodule
